### sv/pot_pkg.sv
// ----------------------------------------------------------------------------
// pot_pkg
// Shared widths, register indexes and reset values for the piezo onset trigger.
// ----------------------------------------------------------------------------
`default_nettype none

package pot_pkg;

	localparam int LEVEL_W     = 24;   // Q1.23 magnitude width
	localparam int LEN_W       = 21;   // sample_length width
	localparam int CFG_IDX_W   = 2;
	localparam int INDEX_BITS_DEF = 20;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DROP      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH    = 2'd3;

	// reset values: 0.8, 0.6, 0.00005 in Q1.23, and a 2^20 frame sample
	localparam logic [LEVEL_W-1:0] THRESHOLD_RST = 24'd6710886;
	localparam logic [LEVEL_W-1:0] DROP_RST      = 24'd5033165;
	localparam logic [LEVEL_W-1:0] DECAY_RST     = 24'd419;
	localparam logic [LEN_W-1:0]   LENGTH_RST    = 21'd1048576;

endpackage

`default_nettype wire

### sv/piezo_onset_trigger_unit.sv
// ----------------------------------------------------------------------------
// piezo_onset_trigger_unit
// Peak-decay onset detector on a rectified piezo stream, driving a playback
// frame index that (re)starts on every trigger.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | dir | moves
//  --------+-------------------------------------------+-----+-------------------
//  in      | in_valid, in_ready, sample_in             | in  | one sample request
//  out     | out_valid, out_ready, rectified,          | out | one result request
//          | peak_level, fired, playing, play_index    |     |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | in  | one register write
//
//  A sample is registered in stage 1 and then in the result register; one
//  request is taken every cycle while out_ready does not stall the result.
//  Stage 1 is the input register; all detector math
//  (rectify, peak compare/decay, fire compare, index advance) sits between
//  it and the result register. Stalls on out_ready hold both stages and
//  backpressure in_ready. Reset clears detector state, valids and registers
//  to their defaults. cfg_ready is always high; accepted writes are registered.
//
`default_nettype none

module piezo_onset_trigger_unit #(
	parameter int INDEX_BITS = pot_pkg::INDEX_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// sample channel
	input  wire logic                              in_valid,
	output      logic                              in_ready,
	input  wire logic signed [pot_pkg::LEVEL_W-1:0] sample_in,
	// result channel
	output      logic                              out_valid,
	input  wire logic                              out_ready,
	output      logic [pot_pkg::LEVEL_W-1:0]       rectified,
	output      logic [pot_pkg::LEVEL_W-1:0]       peak_level,
	output      logic                              fired,
	output      logic                              playing,
	output      logic [INDEX_BITS-1:0]             play_index,
	// configuration channel
	input  wire logic                              cfg_valid,
	output      logic                              cfg_ready,
	input  wire logic [pot_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [pot_pkg::LEVEL_W-1:0]       cfg_data
);
	import pot_pkg::*;

	// wide enough to compare next position against sample_length
	localparam int CMP_W = (INDEX_BITS + 1 > LEN_W) ? INDEX_BITS + 1 : LEN_W;

	// configuration registers
	logic [LEVEL_W-1:0] threshold_q, drop_q, decay_q;
	logic [LEN_W-1:0]   length_q;

	// stage 1: input register
	logic               valid_s1;
	logic [LEVEL_W-1:0] sample_s1;

	// detector state
	logic [LEVEL_W-1:0]    peak_q;
	logic                  latch_q;
	logic                  active_q;
	logic [INDEX_BITS-1:0] pos_q;

	// result register
	logic                  out_valid_q;
	logic [LEVEL_W-1:0]    rect_q, peak_out_q;
	logic                  fired_q, playing_q;
	logic [INDEX_BITS-1:0] index_q;

	// next-value logic
	logic                  advance;
	logic [LEVEL_W-1:0]    rect, peak_n;
	logic                  latch_n, fire, act, stop, active_n;
	logic [INDEX_BITS-1:0] pos_cur, pos_n;
	logic [INDEX_BITS:0]   pos_next;
	logic [CMP_W-1:0]      next_ext, len_ext;

	assign cfg_ready = 1'b1;

	// stage 1 moves into the result register whenever that register frees up
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			drop_q      <= DROP_RST;
			decay_q     <= DECAY_RST;
			length_q    <= LENGTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_THRESHOLD: threshold_q <= cfg_data;
				REG_DROP:      drop_q      <= cfg_data;
				REG_DECAY:     decay_q     <= cfg_data;
				REG_LENGTH:    length_q    <= cfg_data[LEN_W-1:0];
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= sample_in;
		end
	end

	always_comb begin
		// full-wave rectify; the most negative code maps to 1.0 (0x800000)
		rect = sample_s1[LEVEL_W-1] ? (~sample_s1 + 1'b1) : sample_s1;

		// peak tracking: jump up (re-arm) or linear decay
		peak_n  = peak_q;
		latch_n = latch_q;
		if (rect >= peak_q) begin
			peak_n  = rect;
			latch_n = 1'b0;
		end else if (peak_q >= decay_q) begin
			peak_n = peak_q - decay_q;
		end

		// one fire per peak; drop above peak means no fire
		fire = !latch_n && (peak_n >= threshold_q) && (peak_n >= drop_q)
			&& (rect < peak_n - drop_q);
		if (fire) begin
			latch_n = 1'b1;
		end

		// playback index: a fire restarts at frame 0 on this same sample
		act      = fire || active_q;
		pos_cur  = fire ? '0 : pos_q;
		pos_next = {1'b0, pos_cur} + 1'b1;
		next_ext = CMP_W'(pos_next);
		len_ext  = CMP_W'(length_q);
		stop     = (next_ext >= len_ext) || pos_next[INDEX_BITS];
		active_n = act && !stop;
		pos_n    = (act && !stop) ? pos_next[INDEX_BITS-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q      <= '0;
			latch_q     <= 1'b0;
			active_q    <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				peak_q   <= peak_n;
				latch_q  <= latch_n;
				active_q <= active_n;
				pos_q    <= pos_n;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rect_q     <= rect;
			peak_out_q <= peak_n;
			fired_q    <= fire;
			playing_q  <= act;
			index_q    <= act ? pos_cur : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign rectified  = rect_q;
	assign peak_level = peak_out_q;
	assign fired      = fired_q;
	assign playing    = playing_q;
	assign play_index = index_q;

endmodule

`default_nettype wire

### sv/pot_checker.sv
// ----------------------------------------------------------------------------
// pot_checker
// Port-level checks for the piezo onset trigger, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pot_checker #(
	parameter int INDEX_BITS = pot_pkg::INDEX_BITS_DEF
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [pot_pkg::LEVEL_W-1:0]   rectified,
	input wire logic [pot_pkg::LEVEL_W-1:0]   peak_level,
	input wire logic                          fired,
	input wire logic                          playing,
	input wire logic [INDEX_BITS-1:0]         play_index
);
	import pot_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(peak_level)
			&& $stable(play_index) && $stable(fired))
		else $error("result changed while stalled");

	// a fire restarts playback at frame 0 on the same request
	a_fire_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fired |-> playing && play_index == '0)
		else $error("fire did not restart playback");

	// a fire needs the sample well below the peak
	a_fire_below: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fired |-> rectified < peak_level)
		else $error("fire with sample not below peak");

	// idle playback shows frame 0
	a_idle_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !playing |-> play_index == '0)
		else $error("index nonzero while not playing");

endmodule

bind piezo_onset_trigger_unit pot_checker #(.INDEX_BITS(INDEX_BITS)) u_pot_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.rectified  (rectified),
	.peak_level (peak_level),
	.fired      (fired),
	.playing    (playing),
	.play_index (play_index)
);

`default_nettype wire
